// File: rtl/core/kcr_pkg.sv
// ----------------------------------------------------------------------------
// kcr_pkg
// Shared types and constants for the keyboard to console character block.
// ----------------------------------------------------------------------------
package kcr_pkg;

  typedef logic [1:0] opcode_t;

  localparam opcode_t OP_KEY  = 2'd0;
  localparam opcode_t OP_TICK = 2'd1;
  localparam opcode_t OP_READ = 2'd2;
  localparam opcode_t OP_MAP  = 2'd3;

  localparam int CODE_W = 10;
  localparam int CHAR_W = 8;
  localparam int LVL_W  = 6;

  localparam logic [CODE_W-1:0] KC_LSHIFT = 10'd42;
  localparam logic [CODE_W-1:0] KC_RSHIFT = 10'd54;
  localparam logic [CODE_W-1:0] KC_LCTRL  = 10'd29;
  localparam logic [CODE_W-1:0] KC_RCTRL  = 10'd97;
  localparam logic [CODE_W-1:0] KC_LALT   = 10'd56;
  localparam logic [CODE_W-1:0] KC_RALT   = 10'd100;
  localparam logic [CODE_W-1:0] KC_LMETA  = 10'd125;
  localparam logic [CODE_W-1:0] KC_RMETA  = 10'd126;

  localparam int MOD_LSHIFT = 0;
  localparam int MOD_RSHIFT = 1;
  localparam int MOD_LCTRL  = 2;
  localparam int MOD_RCTRL  = 3;
  localparam int MOD_LALT   = 4;
  localparam int MOD_RALT   = 5;
  localparam int MOD_N      = 6;

  localparam logic [CHAR_W-1:0] CHAR_A       = 8'd97;
  localparam logic [CHAR_W-1:0] CTRL_OFFSET  = 8'd96;

  localparam int CFG_AW = 3;
  localparam int CFG_DW = 32;
  localparam int TMR_W  = 16;

  localparam logic [CFG_AW-3:0] REG_DELAY  = 1'd0;
  localparam logic [CFG_AW-3:0] REG_PERIOD = 1'd1;

  localparam logic [TMR_W-1:0] DELAY_RST  = 16'd400;
  localparam logic [TMR_W-1:0] PERIOD_RST = 16'd40;

  typedef struct packed {
    logic [TMR_W-1:0] delay;
    logic [TMR_W-1:0] period;
  } timing_t;

endpackage

// File: rtl/core/kcr_if.sv
// ----------------------------------------------------------------------------
// kcr_if
// Word channels for input events and console results.
// ----------------------------------------------------------------------------
interface kcr_in_if import kcr_pkg::*; ();
  logic              valid;
  logic              ready;
  opcode_t           opcode;
  logic [CODE_W-1:0] key_code;
  logic              key_pressed;
  logic              map_select;
  logic [CHAR_W-1:0] map_char;

  modport source (output valid, opcode, key_code, key_pressed, map_select, map_char,
                  input ready);
  modport sink (input valid, opcode, key_code, key_pressed, map_select, map_char,
                output ready);
endinterface

interface kcr_out_if import kcr_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              char_valid;
  logic [CHAR_W-1:0] char_out;
  logic              has_data;
  logic [LVL_W-1:0]  fifo_level;

  modport source (output valid, char_valid, char_out, has_data, fifo_level,
                  input ready);
  modport sink (input valid, char_valid, char_out, has_data, fifo_level,
                output ready);
endinterface

// File: rtl/core/kcr_ram.sv
// ----------------------------------------------------------------------------
// kcr_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module kcr_ram #(
  parameter int DEPTH = 32,
  parameter int WIDTH = 8,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: rtl/core/kcr_cfg_regs.sv
// ----------------------------------------------------------------------------
// kcr_cfg_regs
// APB register file holding the auto-repeat delay and period.
// ----------------------------------------------------------------------------
module kcr_cfg_regs import kcr_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [CFG_AW-1:0] cfg_paddr,
  input  logic [CFG_DW-1:0] cfg_pwdata,
  output logic [CFG_DW-1:0] cfg_prdata,
  output logic              cfg_pready,
  output timing_t           timing
);

  logic [TMR_W-1:0] delay_r;
  logic [TMR_W-1:0] period_r;
  logic             wr_en;
  logic [CFG_AW-3:0] idx;

  assign idx        = cfg_paddr[CFG_AW-1:2];
  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      delay_r  <= DELAY_RST;
      period_r <= PERIOD_RST;
    end else if (wr_en) begin
      if (idx == REG_DELAY) begin
        delay_r <= cfg_pwdata[TMR_W-1:0];
      end
      if (idx == REG_PERIOD) begin
        period_r <= cfg_pwdata[TMR_W-1:0];
      end
    end
  end

  always_comb begin
    cfg_prdata = '0;
    case (idx)
      REG_DELAY:  cfg_prdata = {{(CFG_DW-TMR_W){1'b0}}, delay_r};
      REG_PERIOD: cfg_prdata = {{(CFG_DW-TMR_W){1'b0}}, period_r};
      default:    cfg_prdata = '0;
    endcase
  end

  assign timing.delay  = delay_r;
  assign timing.period = period_r;

endmodule

// File: rtl/core/keyboard_to_console_char_with_repeat.sv
// ----------------------------------------------------------------------------
// keyboard_to_console_char_with_repeat
// Key events to console characters through loadable keymaps, with auto-repeat.
// Path: keymap/FIFO RAM read and stage-2 registers, then update and output
// register. Throughput: one word per cycle while out_ch.ready does not stall.
// Reset: synchronous active-low; clears modifiers, FIFO pointers and repeat
// state. Keymap and FIFO RAMs are not cleared and must be loaded before use.
// ----------------------------------------------------------------------------
module keyboard_to_console_char_with_repeat import kcr_pkg::*; #(
  parameter int KEY_CODES   = 768,
  parameter int QUEUE_DEPTH = 32,
  parameter int TIMER_BITS  = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  kcr_in_if.sink            in_ch,
  kcr_out_if.source         out_ch,
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [CFG_AW-1:0] cfg_paddr,
  input  logic [CFG_DW-1:0] cfg_pwdata,
  output logic [CFG_DW-1:0] cfg_prdata,
  output logic              cfg_pready
);

  localparam int KA = $clog2(KEY_CODES);
  localparam int QA = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [QA-1:0] PTR_LAST = QA'(QUEUE_DEPTH - 1);
  localparam logic [CW-1:0] CNT_FULL = CW'(QUEUE_DEPTH);

  timing_t timing;

  kcr_cfg_regs u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .timing      (timing)
  );

  // accept stage
  logic accept;
  logic s2_adv;
  logic in_range;
  logic km_re;
  logic nm_we;
  logic sm_we;

  logic              s2_valid_r;
  opcode_t           s2_op_r;
  logic [CODE_W-1:0] s2_code_r;
  logic              s2_pressed_r;
  logic              s2_in_range_r;
  logic              s2_byp_r;
  logic [CHAR_W-1:0] s2_byp_data_r;

  logic [MOD_N-1:0]      mod_r, mod_nxt;
  logic [QA-1:0]         rd_ptr_r, rd_ptr_nxt;
  logic [QA-1:0]         wr_ptr_r, wr_ptr_nxt;
  logic [CW-1:0]         cnt_r, cnt_nxt;
  logic [CHAR_W-1:0]     held_r, held_nxt;
  logic [TIMER_BITS-1:0] cd_r, cd_nxt;
  logic                  armed_r, armed_nxt;

  logic              out_valid_r;
  logic              out_cv_r;
  logic [CHAR_W-1:0] out_ch_r;
  logic              out_hd_r;
  logic [LVL_W-1:0]  out_lvl_r;

  logic [CHAR_W-1:0] nm_rdata;
  logic [CHAR_W-1:0] sm_rdata;
  logic [CHAR_W-1:0] fifo_rdata;

  logic              push;
  logic [CHAR_W-1:0] push_data;
  logic              push_do;
  logic              pop_cv;
  logic [CHAR_W-1:0] pop_char;

  assign s2_adv       = !out_valid_r || out_ch.ready;
  assign in_ch.ready  = !s2_valid_r || s2_adv;
  assign accept       = in_ch.valid && in_ch.ready;
  assign in_range     = ({1'b0, in_ch.key_code} < (CODE_W + 1)'(KEY_CODES));
  assign km_re        = accept && in_range && (in_ch.opcode == OP_KEY);
  assign nm_we        = accept && in_range && (in_ch.opcode == OP_MAP) && !in_ch.map_select;
  assign sm_we        = accept && in_range && (in_ch.opcode == OP_MAP) && in_ch.map_select;

  kcr_ram #(.DEPTH(KEY_CODES), .WIDTH(CHAR_W), .AW(KA)) u_normal_map (
    .clk   (clk),
    .we    (nm_we),
    .waddr (in_ch.key_code[KA-1:0]),
    .wdata (in_ch.map_char),
    .re    (km_re),
    .raddr (in_ch.key_code[KA-1:0]),
    .rdata (nm_rdata)
  );

  kcr_ram #(.DEPTH(KEY_CODES), .WIDTH(CHAR_W), .AW(KA)) u_shift_map (
    .clk   (clk),
    .we    (sm_we),
    .waddr (in_ch.key_code[KA-1:0]),
    .wdata (in_ch.map_char),
    .re    (km_re),
    .raddr (in_ch.key_code[KA-1:0]),
    .rdata (sm_rdata)
  );

  kcr_ram #(.DEPTH(QUEUE_DEPTH), .WIDTH(CHAR_W), .AW(QA)) u_fifo (
    .clk   (clk),
    .we    (push_do),
    .waddr (wr_ptr_r),
    .wdata (push_data),
    .re    (accept),
    .raddr (rd_ptr_nxt),
    .rdata (fifo_rdata)
  );

  // update stage
  logic                  commit;
  logic                  is_mod;
  logic                  is_meta;
  logic [2:0]            slot;
  logic [CHAR_W-1:0]     key_char;
  logic [TIMER_BITS+TMR_W-1:0] delay_ext;
  logic [TIMER_BITS+TMR_W-1:0] period_ext;
  logic [CW+LVL_W-1:0]   lvl_ext;

  assign commit     = s2_valid_r && s2_adv;
  assign delay_ext  = {{TIMER_BITS{1'b0}}, timing.delay};
  assign period_ext = {{TIMER_BITS{1'b0}}, timing.period};

  always_comb begin
    is_mod  = 1'b1;
    is_meta = 1'b0;
    slot    = 3'd0;
    case (s2_code_r)
      KC_LSHIFT: slot = 3'(MOD_LSHIFT);
      KC_RSHIFT: slot = 3'(MOD_RSHIFT);
      KC_LCTRL:  slot = 3'(MOD_LCTRL);
      KC_RCTRL:  slot = 3'(MOD_RCTRL);
      KC_LALT:   slot = 3'(MOD_LALT);
      KC_RALT:   slot = 3'(MOD_RALT);
      KC_LMETA:  is_meta = 1'b1;
      KC_RMETA:  is_meta = 1'b1;
      default:   is_mod = 1'b0;
    endcase
  end

  always_comb begin
    if (mod_r[MOD_LCTRL] || mod_r[MOD_RCTRL]) begin
      key_char = (nm_rdata >= CHAR_A) ? (nm_rdata - CTRL_OFFSET) : '0;
    end else if (mod_r[MOD_LSHIFT] || mod_r[MOD_RSHIFT]) begin
      key_char = sm_rdata;
    end else begin
      key_char = nm_rdata;
    end
  end

  always_comb begin
    mod_nxt    = mod_r;
    held_nxt   = held_r;
    cd_nxt     = cd_r;
    armed_nxt  = armed_r;
    push       = 1'b0;
    push_data  = key_char;
    pop_cv     = 1'b0;
    pop_char   = '0;
    rd_ptr_nxt = rd_ptr_r;
    wr_ptr_nxt = wr_ptr_r;
    cnt_nxt    = cnt_r;
    if (commit) begin
      case (s2_op_r)
        OP_KEY: begin
          if (s2_in_range_r) begin
            if (is_mod) begin
              if (!is_meta) begin
                mod_nxt[slot] = s2_pressed_r;
              end
            end else if (s2_pressed_r) begin
              push      = 1'b1;
              push_data = key_char;
              held_nxt  = key_char;
              cd_nxt    = delay_ext[TIMER_BITS-1:0];
              armed_nxt = 1'b1;
            end else begin
              held_nxt  = '0;
              armed_nxt = 1'b0;
            end
          end
        end
        OP_TICK: begin
          if (armed_r) begin
            if (cd_r > TIMER_BITS'(1)) begin
              cd_nxt = cd_r - TIMER_BITS'(1);
            end else if (held_r != '0) begin
              push      = 1'b1;
              push_data = held_r;
              cd_nxt    = period_ext[TIMER_BITS-1:0];
            end else begin
              cd_nxt    = '0;
              armed_nxt = 1'b0;
            end
          end
        end
        OP_READ: begin
          if (cnt_r != '0) begin
            pop_cv     = 1'b1;
            pop_char   = s2_byp_r ? s2_byp_data_r : fifo_rdata;
            rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + QA'(1);
            cnt_nxt    = cnt_r - CW'(1);
          end
        end
        default: ;
      endcase
    end
    push_do = push && (cnt_r < CNT_FULL);
    if (push_do) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + QA'(1);
      cnt_nxt    = cnt_r + CW'(1);
    end
  end

  assign lvl_ext = {{LVL_W{1'b0}}, cnt_nxt};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      mod_r       <= '0;
      rd_ptr_r    <= '0;
      wr_ptr_r    <= '0;
      cnt_r       <= '0;
      held_r      <= '0;
      cd_r        <= '0;
      armed_r     <= 1'b0;
    end else begin
      if (in_ch.ready) begin
        s2_valid_r <= in_ch.valid;
      end
      if (s2_adv) begin
        out_valid_r <= s2_valid_r;
      end
      mod_r    <= mod_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      wr_ptr_r <= wr_ptr_nxt;
      cnt_r    <= cnt_nxt;
      held_r   <= held_nxt;
      cd_r     <= cd_nxt;
      armed_r  <= armed_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s2_op_r       <= in_ch.opcode;
      s2_code_r     <= in_ch.key_code;
      s2_pressed_r  <= in_ch.key_pressed;
      s2_in_range_r <= in_range;
      s2_byp_r      <= push_do && (wr_ptr_r == rd_ptr_nxt);
      s2_byp_data_r <= push_data;
    end
    if (commit) begin
      out_cv_r  <= pop_cv;
      out_ch_r  <= pop_char;
      out_hd_r  <= (cnt_nxt != '0);
      out_lvl_r <= lvl_ext[LVL_W-1:0];
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.char_valid = out_cv_r;
  assign out_ch.char_out   = out_ch_r;
  assign out_ch.has_data   = out_hd_r;
  assign out_ch.fifo_level = out_lvl_r;

endmodule

// File: verif/keyboard_to_console_char_with_repeat_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// keyboard_to_console_char_with_repeat_test
// Self-checking bench for the keyboard to console character block. Loads the
// keymaps, then drives key, tick, read and keymap words through handshaked
// channels with random gaps and stalls. It writes the repeat timing over APB
// while the block is idle and checks every result word against a local
// prediction of modifiers, keymaps, character queue and auto-repeat.
// ----------------------------------------------------------------------------
module keyboard_to_console_char_with_repeat_test;
  import kcr_pkg::*;

  localparam int KEY_CODES   = 768;
  localparam int QUEUE_DEPTH = 32;
  localparam int CYCLE_LIMIT = 500000;

  typedef struct {
    logic              char_valid;
    logic [CHAR_W-1:0] char_out;
    logic              has_data;
    logic [LVL_W-1:0]  fifo_level;
  } console_status_t;

  logic clk = 1'b0;
  logic rst_n;
  logic              cfg_psel;
  logic              cfg_penable;
  logic              cfg_pwrite;
  logic [CFG_AW-1:0] cfg_paddr;
  logic [CFG_DW-1:0] cfg_pwdata;
  logic [CFG_DW-1:0] cfg_prdata;
  logic              cfg_pready;

  kcr_in_if  in_bus ();
  kcr_out_if out_bus ();

  keyboard_to_console_char_with_repeat #(
    .KEY_CODES   (KEY_CODES),
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .TIMER_BITS  (TMR_W)
  ) dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_bus),
    .out_ch      (out_bus),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  // console state as predicted
  bit                mod_held [MOD_N];
  logic [CHAR_W-1:0] norm_map [KEY_CODES];
  logic [CHAR_W-1:0] shift_map [KEY_CODES];
  bit                norm_set [KEY_CODES];
  bit                shift_set [KEY_CODES];
  logic [CHAR_W-1:0] char_fifo [$];
  logic [CHAR_W-1:0] held_char;
  int unsigned       countdown;
  bit                armed;
  logic [TMR_W-1:0]  delay_reg;
  logic [TMR_W-1:0]  period_reg;

  console_status_t   status_due [$];
  logic [CODE_W-1:0] key_pool [$];
  logic [CODE_W-1:0] mod_keys [8] = '{KC_LSHIFT, KC_RSHIFT, KC_LCTRL, KC_RCTRL,
                                      KC_LALT, KC_RALT, KC_LMETA, KC_RMETA};

  bit send_gaps;
  bit recv_stalls;
  int err_count;
  int words_sent;
  int results_checked;
  int chars_popped;
  int repeats_pushed;
  int pushes_dropped;
  int cycles;
  int stall_left;

  always #4 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles, status_due.size());
      $display("DONE: errors detected");
      $finish;
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(99);
    if (r < 60) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic [TMR_W-1:0] pick_timer();
    int r;
    r = $urandom_range(99);
    if (r < 12) return 16'd1;
    if (r < 18) return 16'hFFFF;
    return 16'($urandom_range(2, 6));
  endfunction

  function automatic int modifier_slot(logic [CODE_W-1:0] code);
    case (code)
      KC_LSHIFT: return MOD_LSHIFT;
      KC_RSHIFT: return MOD_RSHIFT;
      KC_LCTRL:  return MOD_LCTRL;
      KC_RCTRL:  return MOD_RCTRL;
      KC_LALT:   return MOD_LALT;
      KC_RALT:   return MOD_RALT;
      KC_LMETA, KC_RMETA: return MOD_N;
      default:   return -1;
    endcase
  endfunction

  function automatic bit keymap_loaded(logic [CODE_W-1:0] code);
    return code >= KEY_CODES || (norm_set[code] && shift_set[code]);
  endfunction

  function automatic logic [CODE_W-1:0] pick_key();
    return key_pool[$urandom_range(key_pool.size() - 1)];
  endfunction

  function automatic void queue_char(logic [CHAR_W-1:0] c);
    if (char_fifo.size() < QUEUE_DEPTH) char_fifo.push_back(c);
    else pushes_dropped++;
  endfunction

  task automatic apply_console_word(input opcode_t op, input logic [CODE_W-1:0] code,
                                    input logic pressed, input logic sel,
                                    input logic [CHAR_W-1:0] mchar);
    console_status_t st;
    logic [CHAR_W-1:0] c;
    int slot;
    st = '{1'b0, '0, 1'b0, '0};
    case (op)
      OP_KEY: begin
        if (code < KEY_CODES) begin
          slot = modifier_slot(code);
          if (slot >= 0) begin
            if (slot < MOD_N) mod_held[slot] = pressed;
          end else begin
            if (mod_held[MOD_LCTRL] || mod_held[MOD_RCTRL]) begin
              c = norm_map[code];
              c = (c >= CHAR_A) ? c - CTRL_OFFSET : '0;
            end else if (mod_held[MOD_LSHIFT] || mod_held[MOD_RSHIFT]) begin
              c = shift_map[code];
            end else begin
              c = norm_map[code];
            end
            if (pressed) begin
              queue_char(c);
              held_char = c;
              countdown = delay_reg;
              armed = 1'b1;
            end else begin
              held_char = '0;
              armed = 1'b0;
            end
          end
        end
      end
      OP_TICK: begin
        if (armed) begin
          if (countdown > 1) begin
            countdown--;
          end else if (held_char != 0) begin
            queue_char(held_char);
            repeats_pushed++;
            countdown = period_reg;
          end else begin
            countdown = 0;
            armed = 1'b0;
          end
        end
      end
      OP_READ: begin
        if (char_fifo.size() > 0) begin
          st.char_valid = 1'b1;
          st.char_out = char_fifo.pop_front();
          chars_popped++;
        end
      end
      default: begin
        if (code < KEY_CODES) begin
          if (sel) begin
            shift_map[code] = mchar;
            shift_set[code] = 1'b1;
          end else begin
            norm_map[code] = mchar;
            norm_set[code] = 1'b1;
          end
        end
      end
    endcase
    st.has_data = char_fifo.size() != 0;
    st.fifo_level = LVL_W'(char_fifo.size());
    status_due.push_back(st);
  endtask

  task automatic send_word(input opcode_t op, input logic [CODE_W-1:0] code,
                           input logic pressed, input logic sel,
                           input logic [CHAR_W-1:0] mchar);
    int gap;
    gap = send_gaps ? pick_gap() : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_bus.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_bus.opcode = op;
    in_bus.key_code = code;
    in_bus.key_pressed = pressed;
    in_bus.map_select = sel;
    in_bus.map_char = mchar;
    in_bus.valid = 1'b1;
    do @(posedge clk); while (!in_bus.ready);
    words_sent++;
    apply_console_word(op, code, pressed, sel, mchar);
  endtask

  task automatic send_key(input logic [CODE_W-1:0] code, input logic pressed);
    send_word(OP_KEY, code, pressed, 1'($urandom), 8'($urandom));
  endtask

  task automatic send_plain(input opcode_t op);
    send_word(op, 10'($urandom), 1'($urandom), 1'($urandom), 8'($urandom));
  endtask

  task automatic send_map(input logic [CODE_W-1:0] code, input logic sel,
                          input logic [CHAR_W-1:0] mchar);
    send_word(OP_MAP, code, 1'($urandom), sel, mchar);
  endtask

  task automatic drain_queue(input int extra);
    int n;
    n = char_fifo.size() + extra;
    repeat (n) send_plain(OP_READ);
  endtask

  // hold input idle until every result word is back and the pipe is empty
  task automatic settle_console();
    @(negedge clk);
    in_bus.valid = 1'b0;
    while (status_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [CFG_AW-3:0] idx, input logic [TMR_W-1:0] val);
    logic [CFG_DW-1:0] rd;
    @(negedge clk);
    cfg_psel = 1'b1;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b1;
    cfg_paddr = {idx, 2'b00};
    cfg_pwdata = {16'($urandom), val};
    @(negedge clk);
    cfg_penable = 1'b1;
    do @(posedge clk); while (!cfg_pready);
    if (idx == REG_DELAY) delay_reg = val;
    else period_reg = val;
    @(negedge clk);
    cfg_pwrite = 1'b0;
    cfg_penable = 1'b0;
    @(negedge clk);
    cfg_penable = 1'b1;
    do @(posedge clk); while (!cfg_pready);
    rd = cfg_prdata;
    @(negedge clk);
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    if (rd[TMR_W-1:0] !== val) begin
      $error("register %0d readback: expected %0d, got %0d", idx, val, rd[TMR_W-1:0]);
      err_count++;
    end
  endtask

  task automatic retime_repeat(input logic [TMR_W-1:0] dly, input logic [TMR_W-1:0] per);
    settle_console();
    cfg_write(REG_DELAY, dly);
    cfg_write(REG_PERIOD, per);
  endtask

  always @(posedge clk) begin : check_result
    console_status_t want;
    if (rst_n && out_bus.valid && out_bus.ready) begin
      if (status_due.size() == 0) begin
        $error("result word with nothing expected");
        err_count++;
      end else begin
        want = status_due.pop_front();
        results_checked++;
        if (out_bus.char_valid !== want.char_valid) begin
          $error("char_valid: expected %0d, got %0d", want.char_valid, out_bus.char_valid);
          err_count++;
        end
        if (out_bus.char_out !== want.char_out) begin
          $error("char_out: expected %0d, got %0d", want.char_out, out_bus.char_out);
          err_count++;
        end
        if (out_bus.has_data !== want.has_data) begin
          $error("has_data: expected %0d, got %0d", want.has_data, out_bus.has_data);
          err_count++;
        end
        if (out_bus.fifo_level !== want.fifo_level) begin
          $error("fifo_level: expected %0d, got %0d", want.fifo_level, out_bus.fifo_level);
          err_count++;
        end
      end
    end
  end

  initial begin
    out_bus.ready = 1'b0;
    stall_left = 0;
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        out_bus.ready = 1'b0;
        stall_left--;
      end else begin
        out_bus.ready = 1'b1;
        stall_left = recv_stalls ? pick_gap() : 0;
      end
    end
  end

  task automatic load_keymaps();
    int codes [21] = '{0, 1, 2, 16, 30, 31, 64, 127, 128, 255, 256, 300, 383, 384,
                       511, 512, 600, 640, 700, 766, 767};
    logic [CHAR_W-1:0] n;
    logic [CHAR_W-1:0] s;
    foreach (codes[i]) begin
      case (codes[i])
        0:       begin n = 8'h00; s = 8'hFF; end
        1:       begin n = 8'd96; s = 8'h00; end
        2:       begin n = 8'd122; s = 8'd90; end
        511:     begin n = 8'hFF; s = 8'h80; end
        767:     begin n = CHAR_A; s = 8'd65; end
        default: begin n = 8'($urandom); s = 8'($urandom); end
      endcase
      send_map(10'(codes[i]), 1'b0, n);
      send_map(10'(codes[i]), 1'b1, s);
      key_pool.push_back(10'(codes[i]));
    end
    foreach (mod_keys[i]) begin
      send_map(mod_keys[i], 1'b0, 8'($urandom));
      send_map(mod_keys[i], 1'b1, 8'($urandom));
    end
    send_map(10'd768, 1'b0, 8'hA5);
    send_map(10'd1023, 1'b1, 8'h5A);
  endtask

  task automatic check_modifier_mapping();
    send_plain(OP_READ);
    send_key(10'd767, 1'b1);
    send_key(10'd767, 1'b0);
    send_key(KC_LSHIFT, 1'b1);
    send_key(10'd767, 1'b1);
    send_key(KC_LSHIFT, 1'b0);
    send_key(KC_RSHIFT, 1'b1);
    send_key(10'd1, 1'b1);
    send_key(KC_RCTRL, 1'b1);
    send_key(10'd767, 1'b1);
    send_key(10'd1, 1'b1);
    send_key(10'd511, 1'b1);
    send_key(KC_RSHIFT, 1'b0);
    send_key(KC_RCTRL, 1'b0);
    send_key(KC_LALT, 1'b1);
    send_key(KC_RALT, 1'b1);
    send_key(10'd2, 1'b1);
    send_key(KC_LALT, 1'b0);
    send_key(KC_RALT, 1'b0);
    send_key(KC_LMETA, 1'b1);
    send_key(KC_RMETA, 1'b1);
    send_key(10'd768, 1'b1);
    send_key(10'd1023, 1'b1);
    send_key(10'd2, 1'b0);
    drain_queue(1);
  endtask

  task automatic check_auto_repeat();
    retime_repeat(16'd3, 16'd2);
    send_key(10'd300, 1'b1);
    repeat (10) send_plain(OP_TICK);
    send_key(10'd300, 1'b0);
    repeat (3) send_plain(OP_TICK);
    send_key(10'd0, 1'b1);
    repeat (5) send_plain(OP_TICK);
    send_key(10'd0, 1'b0);
    send_key(10'd300, 1'b1);
    send_key(10'd16, 1'b0);
    repeat (6) send_plain(OP_TICK);
    drain_queue(1);
    retime_repeat(16'd0, 16'd0);
    send_key(10'd2, 1'b1);
    repeat (4) send_plain(OP_TICK);
    send_key(10'd2, 1'b0);
    drain_queue(0);
  endtask

  task automatic check_queue_overflow();
    retime_repeat(16'hFFFF, 16'hFFFF);
    send_gaps = 1'b0;
    recv_stalls = 1'b0;
    repeat (QUEUE_DEPTH + 4) begin
      send_key(pick_key(), 1'b1);
      send_plain(OP_TICK);
    end
    drain_queue(1);
    send_gaps = 1'b1;
    recv_stalls = 1'b1;
  endtask

  task automatic run_random_traffic();
    int start;
    int kind;
    int mod_idx;
    int n;
    logic [CODE_W-1:0] k;
    logic [CODE_W-1:0] code;
    opcode_t op;
    start = words_sent;
    while (words_sent - start < 350) begin
      kind = $urandom_range(99);
      send_gaps = $urandom_range(3) != 0;
      recv_stalls = $urandom_range(3) != 0;
      if (kind < 8) begin
        retime_repeat(pick_timer(), pick_timer());
      end else if (kind < 50) begin
        mod_idx = $urandom_range(9);
        if (mod_idx < 8) send_key(mod_keys[mod_idx], 1'b1);
        k = pick_key();
        send_key(k, 1'b1);
        n = $urandom_range(12);
        repeat (n) begin
          send_plain(OP_TICK);
          if ($urandom_range(9) < 3) send_plain(OP_READ);
        end
        send_key(($urandom_range(4) != 0) ? k : pick_key(), 1'b0);
        if (mod_idx < 8 && $urandom_range(3) != 0) send_key(mod_keys[mod_idx], 1'b0);
      end else if (kind < 60) begin
        repeat ($urandom_range(4, 20)) send_key(pick_key(), 1'($urandom));
      end else if (kind < 72) begin
        drain_queue($urandom_range(2));
      end else begin
        repeat ($urandom_range(3, 10)) begin
          op = opcode_t'($urandom);
          code = 10'($urandom);
          if (op == OP_KEY && !keymap_loaded(code)) code = pick_key();
          send_word(op, code, 1'($urandom), 1'($urandom), 8'($urandom));
        end
      end
    end
  endtask

  initial begin
    rst_n = 1'b0;
    in_bus.valid = 1'b0;
    in_bus.opcode = OP_KEY;
    in_bus.key_code = '0;
    in_bus.key_pressed = 1'b0;
    in_bus.map_select = 1'b0;
    in_bus.map_char = '0;
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
    cfg_paddr = '0;
    cfg_pwdata = '0;
    send_gaps = 1'b1;
    recv_stalls = 1'b1;
    delay_reg = DELAY_RST;
    period_reg = PERIOD_RST;
    held_char = '0;
    countdown = 0;
    armed = 1'b0;
    repeat (6) @(negedge clk);
    rst_n = 1'b1;

    load_keymaps();
    check_modifier_mapping();
    check_auto_repeat();
    check_queue_overflow();
    run_random_traffic();
    retime_repeat(16'd1, 16'd1);
    send_key(pick_key(), 1'b1);
    repeat (4) send_plain(OP_TICK);
    send_key(pick_key(), 1'b0);
    drain_queue(1);
    settle_console();
    repeat (8) @(posedge clk);

    $display("covered %0d words, %0d results checked, %0d chars read", words_sent,
             results_checked, chars_popped);
    $display("auto-repeats %0d, pushes dropped on full queue %0d", repeats_pushed,
             pushes_dropped);
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
